[rtl/atpc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// atpc_pkg: shared definitions for the accelerometer pitch classifier
// Widths, stage counts, the arctangent table and the data carried by the
// square-root and CORDIC cells.
// ============================================================================
package atpc_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int TAB_LEN         = 24;
    localparam int ACC_FRAC        = 24;

    // Only the tabled stages are built.
    localparam int CORDIC_N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int SHIFT_W  = $clog2(TAB_LEN);

    // Square root of (y*y + z*z) * 2^32: one result bit per cell.
    localparam int SQ_STEPS = 32;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = 34;
    localparam int RAD_W    = 32;

    localparam int CR_W = 36;   // CORDIC X and Y
    localparam int Z_W  = 32;   // angle accumulator, degrees * 2^24

    localparam int RND_SH    = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int PITCH_LIM = 90 << ANGLE_FRAC_BITS;
    localparam int PITCH_HI  = (PITCH_LIM > 32767) ? 32767 : PITCH_LIM;
    localparam int PITCH_LO  = (PITCH_LIM > 32768) ? -32768 : -PITCH_LIM;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SENSOR_EN = 2'd0;
    localparam logic [1:0] REG_WARN_THR  = 2'd1;
    localparam logic [1:0] REG_CRIT_THR  = 2'd2;

    localparam logic [14:0] WARN_THR_RST = 15'd3840;
    localparam logic [14:0] CRIT_THR_RST = 15'd7680;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_WARNING  = 2'd1,
        ST_CRITICAL = 2'd2,
        ST_SENSOR   = 2'd3
    } t_status;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        logic [15:0]       x;
        logic              err;
        logic              xz;
    } t_sq_data;

    typedef struct packed {
        logic signed [CR_W-1:0] cx;
        logic signed [CR_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
        logic                   err;
        logic                   xz;
    } t_cr_data;

    // atan(2^-i) in degrees * 2^24, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_val(input logic [SHIFT_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd754974720;
            5'd1:    v = 32'sd445687602;
            5'd2:    v = 32'sd235489088;
            5'd3:    v = 32'sd119537938;
            5'd4:    v = 32'sd60000934;
            5'd5:    v = 32'sd30029717;
            5'd6:    v = 32'sd15018523;
            5'd7:    v = 32'sd7509720;
            5'd8:    v = 32'sd3754917;
            5'd9:    v = 32'sd1877466;
            5'd10:   v = 32'sd938734;
            5'd11:   v = 32'sd469367;
            5'd12:   v = 32'sd234684;
            5'd13:   v = 32'sd117342;
            5'd14:   v = 32'sd58671;
            5'd15:   v = 32'sd29335;
            5'd16:   v = 32'sd14668;
            5'd17:   v = 32'sd7334;
            5'd18:   v = 32'sd3667;
            5'd19:   v = 32'sd1833;
            5'd20:   v = 32'sd917;
            5'd21:   v = 32'sd458;
            5'd22:   v = 32'sd229;
            5'd23:   v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/accel_tilt_pitch_classifier_top.sv]
`timescale 1ns / 1ps
// An accepted request passes to the output register through the chain
// (2 front stages, 32 square-root cells, 16 CORDIC cells, rounding and output stages).
// Throughput: one request per cycle when not stalled; every cell then passes its item on.
// The chain stalls only when both the output register and the skid register are full.
// Reset is synchronous and active low; it empties the chain and output and loads
// the register defaults (sensor disabled, warning 3840, critical 7680).
// ============================================================================
// accel_tilt_pitch_classifier_top: accelerometer pitch and tilt classifier
// Pitch = atan2(x, sqrt(y*y + z*z)) in degrees * 256 through a square-root
// cell chain and a CORDIC cell chain, then threshold classification.
// ============================================================================
module accel_tilt_pitch_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic        i_s_axis_tuser,   // sample_complete [0]
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // pitch_angle [15:0]
    output logic [1:0]  o_m_axis_tuser    // tilt_status [1:0]
);
    import atpc_pkg::*;

    // ---------------- configuration registers ----------------
    logic        r_sensor_en;
    logic [14:0] r_warn_thr;
    logic [14:0] r_crit_thr;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_en <= 1'b0;
            r_warn_thr  <= WARN_THR_RST;
            r_crit_thr  <= CRIT_THR_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SENSOR_EN: r_sensor_en <= pwdata[0];
                REG_WARN_THR:  r_warn_thr  <= pwdata[14:0];
                REG_CRIT_THR:  r_crit_thr  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SENSOR_EN: prdata = {31'd0, r_sensor_en};
            REG_WARN_THR:  prdata = {17'd0, r_warn_thr};
            REG_CRIT_THR:  prdata = {17'd0, r_crit_thr};
            default:       prdata = '0;
        endcase
    end

    // ---------------- chain control ----------------
    logic r_skid_v;
    logic en;
    logic in_req;

    assign en              = ~r_skid_v;
    assign o_s_axis_tready = en;
    assign in_req          = i_s_axis_tvalid & en;

    // ---------------- front stages: squares, then radicand ----------------
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
    logic signed [31:0] yy;
    logic signed [31:0] zz;

    logic        r_a_v;
    logic [31:0] r_a_yy;
    logic [31:0] r_a_zz;
    logic [15:0] r_a_x;
    logic        r_a_err;
    logic        r_a_xz;

    logic        r_b_v;
    t_sq_data    r_b_d;

    assign in_x = i_s_axis_tdata[15:0];
    assign in_y = i_s_axis_tdata[31:16];
    assign in_z = i_s_axis_tdata[47:32];
    assign yy   = in_y * in_y;
    assign zz   = in_z * in_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_a_v <= in_req;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_yy  <= yy;
            r_a_zz  <= zz;
            r_a_x   <= in_x;
            r_a_err <= ~r_sensor_en | ~i_s_axis_tuser;
            r_a_xz  <= (in_x == 16'sd0);

            r_b_d.rem  <= '0;
            r_b_d.root <= '0;
            r_b_d.rad  <= r_a_yy + r_a_zz;
            r_b_d.x    <= r_a_x;
            r_b_d.err  <= r_a_err;
            r_b_d.xz   <= r_a_xz;
        end
    end

    // ---------------- square-root chain ----------------
    logic     sq_v [0:SQ_STEPS];
    t_sq_data sq_d [0:SQ_STEPS];

    assign sq_v[0] = r_b_v;
    assign sq_d[0] = r_b_d;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        atpc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // ---------------- CORDIC chain ----------------
    logic     cr_v [0:CORDIC_N];
    t_cr_data cr_d [0:CORDIC_N];

    assign cr_v[0]     = sq_v[SQ_STEPS];
    assign cr_d[0].cx  = signed'({{(CR_W-ROOT_W){1'b0}}, sq_d[SQ_STEPS].root});
    assign cr_d[0].cy  = signed'({{(CR_W-32){sq_d[SQ_STEPS].x[15]}},
                                  sq_d[SQ_STEPS].x, 16'd0});
    assign cr_d[0].z   = '0;
    assign cr_d[0].err = sq_d[SQ_STEPS].err;
    assign cr_d[0].xz  = sq_d[SQ_STEPS].xz;

    for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
        atpc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (SHIFT_W'(g)),
            .i_valid (cr_v[g]),
            .i_data  (cr_d[g]),
            .o_valid (cr_v[g+1]),
            .o_data  (cr_d[g+1])
        );
    end

    // ---------------- rounding and clamping ----------------
    logic signed [Z_W:0] z_rnd;
    logic signed [Z_W:0] z_sh;
    logic signed [15:0]  pitch_cl;

    logic               r_p_v;
    logic signed [15:0] r_p_pitch;
    logic               r_p_err;

    always_comb begin
        z_rnd = signed'({cr_d[CORDIC_N].z[Z_W-1], cr_d[CORDIC_N].z})
              + signed'((Z_W+1)'(1) << (RND_SH - 1));
        z_sh  = z_rnd >>> RND_SH;
        priority if (cr_d[CORDIC_N].xz) begin
            pitch_cl = '0;   // no forward component: level by definition
        end else if (z_sh > signed'((Z_W+1)'(PITCH_HI))) begin
            pitch_cl = 16'(PITCH_HI);
        end else if (z_sh < signed'((Z_W+1)'(PITCH_LO))) begin
            pitch_cl = 16'(PITCH_LO);
        end else begin
            pitch_cl = z_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= cr_v[CORDIC_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_pitch <= pitch_cl;
            r_p_err   <= cr_d[CORDIC_N].err;
        end
    end

    // ---------------- classification ----------------
    logic [16:0]  mag;
    logic [15:0]  n_pitch;
    t_status      n_status;

    always_comb begin
        mag = r_p_pitch[15] ? 17'(-{r_p_pitch[15], r_p_pitch})
                            : {1'b0, r_p_pitch};
        priority if (r_p_err) begin
            n_pitch  = '0;
            n_status = ST_SENSOR;
        end else if (mag >= {2'b00, r_crit_thr}) begin
            n_pitch  = r_p_pitch;
            n_status = ST_CRITICAL;
        end else if (mag >= {2'b00, r_warn_thr}) begin
            n_pitch  = r_p_pitch;
            n_status = ST_WARNING;
        end else begin
            n_pitch  = r_p_pitch;
            n_status = ST_NORMAL;
        end
    end

    // ---------------- output register with skid stage ----------------
    logic        r_out_v;
    logic [15:0] r_out_pitch;
    t_status     r_out_status;
    logic [15:0] r_skid_pitch;
    t_status     r_skid_status;
    logic        out_take;

    assign out_take = r_out_v & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_p_v) begin
            if (!r_out_v || out_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out_pitch  <= r_skid_pitch;
                r_out_status <= r_skid_status;
            end
        end else if (r_p_v) begin
            if (!r_out_v || out_take) begin
                r_out_pitch  <= n_pitch;
                r_out_status <= n_status;
            end else begin
                r_skid_pitch  <= n_pitch;
                r_skid_status <= n_status;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_pitch;
    assign o_m_axis_tuser  = r_out_status;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output register is empty");

    a_error_zero_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_status == ST_SENSOR) |-> (r_out_pitch == 16'd0))
        else $error("sensor error result carries a nonzero pitch");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v |-> ($signed(r_p_pitch) <= PITCH_HI && $signed(r_p_pitch) >= PITCH_LO))
        else $error("pitch outside the clamp range");

    a_stall_holds_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && r_p_v) |=> r_p_v)
        else $error("pending result dropped while the chain was stalled");

endmodule

[rtl/atpc_sqrt_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// atpc_sqrt_cell: one digit of the restoring square root
// Takes the next two radicand bits, tries to subtract 4*root+1 from the
// partial remainder and shifts one result bit into the root.
// ============================================================================
module atpc_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  atpc_pkg::t_sq_data i_data,
    output logic               o_valid,
    output atpc_pkg::t_sq_data o_data
);
    import atpc_pkg::*;

    logic               r_valid;
    t_sq_data           r_data;
    t_sq_data           n_data;
    logic [REM_W+1:0]   cur;
    logic [REM_W+2:0]   trial;
    logic               fits;

    always_comb begin
        cur   = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
        trial = {1'b0, cur} - {3'b000, i_data.root, 2'b01};
        fits  = ~trial[REM_W+2];

        n_data      = i_data;
        n_data.rem  = fits ? trial[REM_W-1:0] : cur[REM_W-1:0];
        n_data.root = {i_data.root[ROOT_W-2:0], fits};
        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/atpc_cordic_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// atpc_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates (X, Y) toward the X axis by atan(2^-i) and accumulates the angle.
// ============================================================================
module atpc_cordic_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [atpc_pkg::SHIFT_W-1:0]    i_shift,
    input  logic                            i_valid,
    input  atpc_pkg::t_cr_data              i_data,
    output logic                            o_valid,
    output atpc_pkg::t_cr_data              o_data
);
    import atpc_pkg::*;

    logic                   r_valid;
    t_cr_data               r_data;
    t_cr_data               n_data;
    logic signed [CR_W-1:0] dx;
    logic signed [CR_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;

    always_comb begin
        dx     = i_data.cx >>> i_shift;
        dy     = i_data.cy >>> i_shift;
        ang    = atan_val(i_shift);
        n_data = i_data;
        if (!i_data.cy[CR_W-1]) begin
            n_data.cx = i_data.cx + dy;
            n_data.cy = i_data.cy - dx;
            n_data.z  = i_data.z + ang;
        end else begin
            n_data.cx = i_data.cx - dy;
            n_data.cy = i_data.cy + dx;
            n_data.z  = i_data.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[test/accel_tilt_pitch_classifier_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// accel_tilt_pitch_classifier_top_tb: pitch and tilt classifier testbench
// Streams accelerometer samples into the classifier under random source and
// sink stalls. Each accepted request is predicted with an independent
// square-root and CORDIC model, and the prediction is checked in order against
// the result stream. The threshold and enable registers are written over the
// APB port between phases and read back.
// ============================================================================
module accel_tilt_pitch_classifier_top_tb;
    import atpc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;
    localparam int N_STEPS     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int FRAC        = ANGLE_FRAC_BITS;

    // atan(2^-i) in degrees * 2^24.
    localparam longint ATAN_DEG24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               complete;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] pitch;
        t_status            status;
    } t_tilt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    // Shadow copy of the configuration registers.
    logic        cfg_enabled = 1'b0;
    logic [14:0] cfg_warn = WARN_THR_RST;
    logic [14:0] cfg_crit = CRIT_THR_RST;

    t_tilt       tilt_expected_q [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          tx_quiet = 0;
    int          rx_quiet = 0;
    int          rx_wait = 0;

    accel_tilt_pitch_classifier_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Floor square root, one result bit per pass.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] pitch_of(input t_sample s);
        longint      cx;
        longint      cy;
        longint      ang;
        longint      dx;
        longint      dy;
        longint      r;
        longint      lim;
        logic [63:0] mag2;
        if (s.x == 0) return '0;
        mag2 = longint'(s.y) * longint'(s.y) + longint'(s.z) * longint'(s.z);
        cx = longint'(floor_root(mag2 << 32));
        cy = longint'(s.x) * 65536;
        ang = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy >= 0) begin
                cx = cx + dy;
                cy = cy - dx;
                ang = ang + ATAN_DEG24[i];
            end else begin
                cx = cx - dy;
                cy = cy + dx;
                ang = ang - ATAN_DEG24[i];
            end
        end
        r = (ang + (longint'(1) <<< (24 - FRAC - 1))) >>> (24 - FRAC);
        lim = longint'(90) <<< FRAC;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_tilt predict_tilt(input t_sample s);
        t_tilt  t;
        longint mag;
        if (!cfg_enabled || !s.complete) begin
            t.pitch = '0;
            t.status = ST_SENSOR;
            return t;
        end
        t.pitch = pitch_of(s);
        mag = (t.pitch < 0) ? -longint'(t.pitch) : longint'(t.pitch);
        if (mag >= cfg_crit)
            t.status = ST_CRITICAL;
        else if (mag >= cfg_warn)
            t.status = ST_WARNING;
        else
            t.status = ST_NORMAL;
        return t;
    endfunction

    // Per-request stall of random length, with occasional stretches of none.
    function automatic int draw_stall(inout int quiet);
        if (quiet > 0) begin
            quiet = quiet - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Result sink: random stalls, and an in-order check of every result.
    always @(posedge i_clk) begin
        t_tilt got;
        t_tilt want;
        int    stall;
        if (i_rst_n) begin
            if (m_tready && o_m_axis_tvalid) begin
                got.pitch = o_m_axis_tdata;
                got.status = t_status'(o_m_axis_tuser);
                if (tilt_expected_q.size() == 0) begin
                    $error("unexpected result: pitch_angle %0d tilt_status %0d",
                           got.pitch, got.status);
                    fail_count++;
                end else begin
                    want = tilt_expected_q.pop_front();
                    if (got.pitch !== want.pitch) begin
                        $error("pitch_angle: expected %0d, actual %0d", want.pitch, got.pitch);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("tilt_status: expected %0d, actual %0d",
                               want.status, o_m_axis_tuser);
                        fail_count++;
                    end
                end
                stall = draw_stall(rx_quiet);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    rx_wait <= stall;
                end
            end else if (!m_tready) begin
                if (rx_wait <= 1)
                    m_tready <= 1'b1;
                else
                    rx_wait <= rx_wait - 1;
            end
        end
    end

    // Sends one sample and leaves tvalid high; a following call in the same
    // step either keeps it high or lowers it, and end_stream lowers it.
    task automatic send_sample(input t_sample s);
        int gap;
        gap = draw_stall(tx_quiet);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s.z, s.y, s.x};
        s_tuser <= s.complete;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tilt_expected_q.push_back(predict_tilt(s));
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
        while (tilt_expected_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("register %0d: expected %0d, actual %0d", idx, want, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SENSOR_EN: cfg_enabled = value[0];
            REG_WARN_THR:  cfg_warn = value[14:0];
            REG_CRIT_THR:  cfg_crit = value[14:0];
            default: ;
        endcase
        @(posedge i_clk);
        case (idx)
            REG_SENSOR_EN: read_check(idx, {31'd0, cfg_enabled});
            REG_WARN_THR:  read_check(idx, {17'd0, cfg_warn});
            default:       read_check(idx, {17'd0, cfg_crit});
        endcase
    endtask

    task automatic set_config(input logic en, input int warn, input int crit);
        end_stream();
        write_reg(REG_SENSOR_EN, {31'd0, en});
        write_reg(REG_WARN_THR, warn);
        write_reg(REG_CRIT_THR, crit);
    endtask

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom_range(0, 255) - 128);
            1: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return -16'sd1;
                    3:       return 16'sd1;
                    default: return 16'sd0;
                endcase
            end
            2:       return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.x = ($urandom_range(0, 15) == 0) ? 16'sd0 : random_axis();
        s.y = random_axis();
        s.z = random_axis();
        s.complete = ($urandom_range(0, 9) != 0);
        return s;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    // Register reset values, and samples while the sensor is still disabled.
    task automatic test_reset_state();
        read_check(REG_SENSOR_EN, 32'd0);
        read_check(REG_WARN_THR, {17'd0, WARN_THR_RST});
        read_check(REG_CRIT_THR, {17'd0, CRIT_THR_RST});
        send_sample('{16'sh7fff, 16'sd0, 16'sd0, 1'b1});
        send_sample('{16'sh8000, 16'sd5, 16'sd9, 1'b0});
        send_random(6);
    endtask

    // Axis extremes, zero forward axis, the +-90 degree clamp and short samples.
    task automatic test_directed_samples();
        t_sample list [18];
        list = '{
            '{16'sd0,      16'sd0,      16'sd0,      1'b1},
            '{16'sd0,      16'sh8000,   16'sh8000,   1'b1},
            '{16'sd0,      16'sd123,    -16'sd77,    1'b1},
            '{16'sh7fff,   16'sd0,      16'sd0,      1'b1},
            '{16'sh8000,   16'sd0,      16'sd0,      1'b1},
            '{16'sd1,      16'sd0,      16'sd0,      1'b1},
            '{-16'sd1,     16'sd0,      16'sd0,      1'b1},
            '{16'sd1,      16'sh8000,   16'sh8000,   1'b1},
            '{-16'sd1,     16'sh7fff,   16'sh7fff,   1'b1},
            '{16'sh7fff,   16'sh7fff,   16'sh7fff,   1'b1},
            '{16'sh8000,   16'sh8000,   16'sh8000,   1'b1},
            '{16'sh8000,   16'sh7fff,   16'sh8000,   1'b1},
            '{16'sd16384,  16'sd0,      16'sd28378,  1'b1},
            '{-16'sd16384, 16'sd28378,  16'sd0,      1'b1},
            '{16'sd5000,   -16'sd12000, 16'sd3000,   1'b1},
            '{16'sh7fff,   16'sd0,      16'sd0,      1'b0},
            '{16'sd0,      16'sd0,      16'sd0,      1'b0},
            '{-16'sd12345, 16'sd22222,  -16'sd1,     1'b1}
        };
        set_config(1'b1, int'(WARN_THR_RST), int'(CRIT_THR_RST));
        foreach (list[i]) send_sample(list[i]);
    endtask

    // Threshold extremes: zero, the +-90 degree bound with a tie, out of range,
    // and a warning level above the critical one.
    task automatic test_threshold_limits();
        set_config(1'b1, 0, 0);
        send_sample('{16'sd0, 16'sd100, 16'sd100, 1'b1});
        send_random(150);
        set_config(1'b1, 0, 23040);
        send_sample('{16'sh8000, 16'sd0, 16'sd0, 1'b1});
        send_random(150);
        set_config(1'b1, 23040, 23040);
        send_sample('{16'sh7fff, 16'sd0, 16'sd0, 1'b1});
        send_sample('{16'sh8000, 16'sd0, 16'sd0, 1'b1});
        send_random(150);
        set_config(1'b1, 32767, 32767);
        send_random(100);
        set_config(1'b1, 15000, 2000);
        send_random(200);
    endtask

    // Bulk traffic with random thresholds, plus a disabled stretch.
    task automatic test_random_traffic();
        int warn;
        int crit;
        for (int phase = 0; phase < 5; phase++) begin
            warn = $urandom_range(0, 23040);
            crit = $urandom_range(warn, 23040);
            set_config(1'b1, warn, crit);
            send_random(250);
        end
        set_config(1'b0, $urandom_range(0, 23040), $urandom_range(0, 23040));
        send_random(100);
        set_config(1'b1, int'(WARN_THR_RST), int'(CRIT_THR_RST));
        send_random(200);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_samples();
        test_threshold_limits();
        test_random_traffic();
        end_stream();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && tilt_expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/atpc_pkg.sv
rtl/atpc_sqrt_cell.sv
rtl/atpc_cordic_cell.sv
rtl/accel_tilt_pitch_classifier_top.sv
test/accel_tilt_pitch_classifier_top_tb.sv
